### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, ignored while reset is high.
`define PF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check that also holds across reset.
`define PF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### rtl/core/pfmt_pkg.sv
// Shared types, codes and character constants of the integer formatter.
package pfmt_pkg;

  localparam int SatLimit   = 47;
  localparam int DigitBuf   = 32;
  localparam int DigIdxW    = $clog2(DigitBuf);

  localparam logic [2:0] ConvSdec = 3'd0;
  localparam logic [2:0] ConvUdec = 3'd1;
  localparam logic [2:0] ConvLhex = 3'd2;
  localparam logic [2:0] ConvUhex = 3'd3;
  localparam logic [2:0] ConvBin  = 3'd4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef enum logic [1:0] {
    BASE10,
    BASE16,
    BASE2
  } base_t;

  typedef struct packed {
    logic [31:0] mag;
    base_t       base;
    logic        upper;
    logic        neg;
    logic        lj;
    logic        fs;
    logic        ss;
    logic        zp;
    logic [5:0]  width;
    logic [5:0]  prec;
  } item_t;

  typedef struct packed {
    logic [DigitBuf-1:0][3:0] digits;
    logic                     upper;
    logic [7:0]               sign_char;
    logic [5:0]               count;
    logic [5:0]               b1;
    logic [5:0]               b2;
    logic [5:0]               b3;
    logic [5:0]               b4;
    logic [5:0]               len;
  } emit_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = ChZero + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d - 4'd10};
    else c = 8'h61 + {4'd0, d - 4'd10};
    return c;
  endfunction

  function automatic logic [5:0] sat47(input logic [5:0] x);
    return (x > 6'(SatLimit)) ? 6'(SatLimit) : x;
  endfunction

endpackage

### rtl/core/pfmt_extract.sv
// Iterative digit extraction, one digit per cycle, least significant first.
module pfmt_extract (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfmt_pkg::item_t      in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfmt_pkg::item_t      out_item,
  output logic [pfmt_pkg::DigitBuf-1:0][3:0] out_digits,
  output logic [5:0]           out_count
);
  import pfmt_pkg::*;

  logic                     busy;
  logic                     done;
  item_t                    item;
  logic [31:0]              mag;
  logic [5:0]               cnt;
  logic [DigitBuf-1:0][3:0] digs;
  logic [63:0]              prod;
  logic [31:0]              quo;
  logic [31:0]              rem_w;
  logic [3:0]               dig;
  logic [31:0]              mag_next;

  // divide by ten through the reciprocal 0xCCCCCCCD / 2^35
  assign prod  = 64'(mag) * 64'h0000_0000_CCCC_CCCD;
  assign quo   = {3'd0, prod[63:35]};
  assign rem_w = mag - {quo[28:0], 3'd0} - {quo[30:0], 1'b0};

  always_comb begin
    unique case (item.base)
      BASE16: begin
        dig      = mag[3:0];
        mag_next = {4'd0, mag[31:4]};
      end
      BASE2: begin
        dig      = {3'd0, mag[0]};
        mag_next = {1'b0, mag[31:1]};
      end
      default: begin
        dig      = rem_w[3:0];
        mag_next = quo;
      end
    endcase
  end

  assign in_ready   = !busy && !done;
  assign out_valid  = done;
  assign out_item   = item;
  assign out_digits = digs;
  assign out_count  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item <= in_item;
        mag  <= in_item.mag;
        cnt  <= '0;
        busy <= 1'b1;
      end
      if (busy) begin
        digs[cnt[DigIdxW-1:0]] <= dig;
        mag <= mag_next;
        cnt <= cnt + 6'd1;
        if (mag_next == '0 || cnt == 6'(DigitBuf - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (done && out_ready) done <= 1'b0;
    end
  end
endmodule

### rtl/core/pfmt_emit.sv
// Character sequencer: walks the field layout and emits one character per transfer.
module pfmt_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfmt_pkg::emit_job_t in_job,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import pfmt_pkg::*;

  logic                busy;
  emit_job_t           job;
  logic [5:0]          pos;
  logic [DigIdxW-1:0]  didx;
  logic [7:0]          ch;
  logic                in_dig;
  logic                adv;
  logic                fin;

  always_comb begin
    in_dig = 1'b0;
    priority if (pos < job.b1) ch = ChSpace;
    else if (pos < job.b2) ch = job.sign_char;
    else if (pos < job.b3) ch = ChZero;
    else if (pos < job.b4) begin
      ch     = digit_char(job.digits[didx], job.upper);
      in_dig = 1'b1;
    end else ch = ChSpace;
  end

  assign in_ready = !busy;
  assign adv      = busy && (!m_tvalid || m_tready);
  assign fin      = (pos == job.len - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      pos      <= '0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
        m_tdata  <= ch;
        m_tlast  <= fin;
        pos      <= pos + 6'd1;
        if (in_dig) didx <= didx - 1'b1;
        if (fin) busy <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_valid && !busy) begin
        job  <= in_job;
        pos  <= '0;
        didx <= in_job.count[DigIdxW-1:0] - 1'b1;
        busy <= 1'b1;
      end
    end
  end
endmodule

### rtl/core/printf_integer_formatter.sv
// Top level of the printf-style integer formatter.
// One transfer in carries a value and its format; the field leaves as ASCII
// characters, one per cycle while the sink is ready, tlast on the final one.
// An item passes an input register, a digit unit that produces one digit per
// cycle (up to 10 for decimal, 8 for hex, 32 for binary), a layout register
// and a character sequencer that emits max(width, sign + digits) characters,
// up to 48. The stages overlap, so the sustained rate is set by the longer
// of digit extraction and emission when the sink does not stall.
module printf_integer_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[31:0], conversion[34:32], left_justify[35], force_sign[36],
  // space_sign[37], zero_pad[38], field_width[44:39], min_digits[50:45]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_char[7:0]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);
  import pfmt_pkg::*;

  logic                     s1_v;
  item_t                    s1;
  item_t                    s_item;
  logic [31:0]              val;
  logic [2:0]               conv;
  logic                     ex_in_ready;
  logic                     ex_v;
  logic                     ex_ready;
  item_t                    ex_item;
  logic [DigitBuf-1:0][3:0] ex_digs;
  logic [5:0]               ex_cnt;
  logic                     s3_v;
  emit_job_t                s3;
  emit_job_t                job_next;
  logic                     em_ready;
  logic [5:0]               ndig;
  logic [5:0]               body;
  logic [5:0]               len;
  logic [5:0]               pad;
  logic [5:0]               zeros;
  logic                     hs;

  assign val  = s_tdata[31:0];
  assign conv = s_tdata[34:32];

  always_comb begin
    s_item.neg   = (conv == ConvSdec) && val[31];
    s_item.mag   = s_item.neg ? (32'd0 - val) : val;
    s_item.upper = (conv == ConvUhex);
    s_item.lj    = s_tdata[35];
    s_item.fs    = s_tdata[36];
    s_item.ss    = s_tdata[37];
    s_item.zp    = s_tdata[38];
    s_item.width = sat47(s_tdata[44:39]);
    s_item.prec  = sat47(s_tdata[50:45]);
    if (conv == ConvLhex || conv == ConvUhex) s_item.base = BASE16;
    else if (conv == ConvBin) s_item.base = BASE2;
    else s_item.base = BASE10;
  end

  assign s_tready = !s1_v || ex_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        s1_v <= 1'b1;
        s1   <= s_item;
      end else if (ex_in_ready) begin
        s1_v <= 1'b0;
      end
    end
  end

  pfmt_extract u_extract (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_v),
    .in_ready   (ex_in_ready),
    .in_item    (s1),
    .out_valid  (ex_v),
    .out_ready  (ex_ready),
    .out_item   (ex_item),
    .out_digits (ex_digs),
    .out_count  (ex_cnt)
  );

  always_comb begin
    hs    = ex_item.neg || ex_item.fs || ex_item.ss;
    ndig  = (ex_item.prec > ex_cnt) ? ex_item.prec : ex_cnt;
    body  = ndig + {5'd0, hs};
    len   = (ex_item.width > body) ? ex_item.width : body;
    pad   = len - body;
    zeros = ((!ex_item.lj && ex_item.zp) ? pad : 6'd0) + (ndig - ex_cnt);
    job_next.digits    = ex_digs;
    job_next.upper     = ex_item.upper;
    job_next.count     = ex_cnt;
    job_next.sign_char = ex_item.neg ? ChMinus : (ex_item.ss ? ChSpace : ChPlus);
    job_next.b1        = (!ex_item.lj && !ex_item.zp) ? pad : 6'd0;
    job_next.b2        = job_next.b1 + {5'd0, hs};
    job_next.b3        = job_next.b2 + zeros;
    job_next.b4        = job_next.b3 + ex_cnt;
    job_next.len       = len;
  end

  assign ex_ready = !s3_v || em_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      if (ex_v && ex_ready) begin
        s3_v <= 1'b1;
        s3   <= job_next;
      end else if (em_ready) begin
        s3_v <= 1'b0;
      end
    end
  end

  pfmt_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s3_v),
    .in_ready (em_ready),
    .in_job   (s3),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );
endmodule

### rtl/core/pfmt_checker.sv
// Port-level checks of the formatter, bound to the top level.
`include "assert_macros.svh"

module pfmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);
  `PF_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `PF_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_tvalid)
  `PF_ASSERT(a_ascii, clk, rst, m_tvalid |-> m_tdata >= 8'h20 && m_tdata <= 8'h7a)
endmodule

bind printf_integer_formatter pfmt_checker u_pfmt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### test/tb_printf_integer_formatter.sv
// Testbench for the integer field formatter: random and directed formats, scoreboarded output.
module tb_printf_integer_formatter;
  timeunit 1ns;
  timeprecision 1ps;
  import pfmt_pkg::*;

  class field_scoreboard;
    logic [7:0] chars_due[$];
    logic       last_due[$];
    int         errors;

    function void note_item(input logic [55:0] d);
      logic [31:0] v, mag;
      logic [2:0]  conv;
      logic        lj, fs, ss, zp, neg, has_sign;
      int          w, p, radix, cnt, ndig, body, len, pad, i;
      logic [7:0]  sc;
      logic [7:0]  digs[$];
      logic [7:0]  fld[$];
      v = d[31:0]; conv = d[34:32]; lj = d[35]; fs = d[36]; ss = d[37]; zp = d[38];
      w = d[44:39]; p = d[50:45];
      if (w > SatLimit) w = SatLimit;
      if (p > SatLimit) p = SatLimit;
      neg = (conv == ConvSdec) && v[31];
      mag = neg ? -v : v;
      radix = (conv == ConvLhex || conv == ConvUhex) ? 16 : (conv == ConvBin ? 2 : 10);
      cnt = 0;
      do begin
        i = mag % radix;
        digs.push_front(i < 10 ? 8'h30 + i[7:0] :
                        ((conv == ConvUhex) ? 8'h41 : 8'h61) + i[7:0] - 8'd10);
        mag = mag / radix;
        cnt++;
      end while (mag != 0 && cnt < DigitBuf);
      ndig = p > cnt ? p : cnt;
      has_sign = neg || fs || ss;
      sc = neg ? ChMinus : (ss ? ChSpace : ChPlus);
      body = ndig + (has_sign ? 1 : 0);
      len = w > body ? w : body;
      pad = len - body;
      if (!lj && !zp) repeat (pad) fld.push_back(ChSpace);
      if (has_sign) fld.push_back(sc);
      if (!lj && zp) repeat (pad) fld.push_back(ChZero);
      repeat (ndig - cnt) fld.push_back(ChZero);
      foreach (digs[k]) fld.push_back(digs[k]);
      if (lj) repeat (pad) fld.push_back(ChSpace);
      foreach (fld[k]) begin
        chars_due.push_back(fld[k]);
        last_due.push_back(k == fld.size() - 1);
      end
    endfunction

    function void check_char(input logic [7:0] c, input logic l);
      logic [7:0] ec;
      logic       el;
      if (chars_due.size() == 0) begin
        $display("%0t: unexpected char exp none act %h last %b", $time, c, l);
        errors++;
        return;
      end
      ec = chars_due.pop_front();
      el = last_due.pop_front();
      if (c !== ec) begin
        $display("%0t: char mismatch exp %h act %h", $time, ec, c);
        errors++;
      end
      if (l !== el) begin
        $display("%0t: tlast mismatch exp %b act %b", $time, el, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, m_tready = 0;
  logic [55:0] s_tdata = '0;
  logic        s_tready, m_tvalid, m_tlast;
  logic [7:0]  m_tdata;
  field_scoreboard sb = new();
  int          idle_cycles = 0;
  bit          hold_sink = 0;

  printf_integer_formatter uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sink stall pattern: quiet stretches, busy stretches, one long hold
  always @(posedge clk) begin
    if (rst || hold_sink) m_tready <= 0;
    else if (($time / 400) % 3 == 0) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [55:0] make_item(input logic [31:0] v, input logic [2:0] cv,
      input logic [3:0] fl, input logic [5:0] w, input logic [5:0] p);
    return {5'd0, p, w, fl[3], fl[2], fl[1], fl[0], cv, v};
  endfunction

  task automatic send(input logic [55:0] d);
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic gap();
    s_tvalid <= 0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  function automatic logic [55:0] rand_item();
    logic [31:0] v;
    logic [5:0]  w, p;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 20);
      1: v = -$urandom_range(0, 20);
      2: v = {1'($urandom_range(0, 1)), 31'd0} | 32'($urandom_range(0, 1));
      default: v = $urandom;
    endcase
    w = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    p = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    return make_item(v, 3'($urandom), 4'($urandom), w, p);
  endfunction

  initial begin
    logic [2:0] cv;
    int burst;
    bit held;
    held = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int k = 0; k < 5; k++) begin
      cv = 3'(k);
      send(make_item(32'h8000_0000, cv, 4'b0000, 6'd0, 6'd0));
      send(make_item(32'hFFFF_FFFF, cv, 4'b0010, 6'd47, 6'd0));
      send(make_item(32'd0, cv, 4'b0100, 6'd0, 6'd0));
      send(make_item(32'd42, cv, 4'b1000, 6'd20, 6'd5));
    end
    send(make_item(32'd7, 3'd6, 4'b0110, 6'd63, 6'd63));
    send(make_item(32'hFFFF_FFF9, ConvSdec, 4'b1001, 6'd12, 6'd3));
    send(make_item(32'h7FFF_FFFF, 3'd7, 4'b1111, 6'd50, 6'd2));
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.chars_due.size() != 0) @(posedge clk);
    for (int n = 0; n < 450; ) begin
      if (n >= 200 && !held) begin
        held = 1;
        hold_sink = 1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_sink = 0;
          end
        join_none
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send(rand_item());
        n++;
      end
      if ($urandom_range(0, 2) == 0) gap();
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.chars_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.chars_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pfmt_pkg.sv
rtl/core/pfmt_extract.sv
rtl/core/pfmt_emit.sv
rtl/core/printf_integer_formatter.sv
rtl/core/pfmt_checker.sv
test/tb_printf_integer_formatter.sv
